// ===== hw/rtl/bwps_pkg.sv =====
// ----------------------------------------------------------------------------
// bwps_pkg
// Shared types and constants for the block Walsh pattern sums unit.
// ----------------------------------------------------------------------------
package bwps_pkg;

  localparam int MAX_WINDOW_DEF = 1024;
  localparam int PIXEL_BITS     = 16;
  localparam int PIX_W          = 16;
  localparam int NSUMS          = 6;
  localparam int SUM_W          = 20;
  localparam int ADDR_W         = 5;

  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_WINDOW_SIZE  = 3'd2;
  localparam logic [2:0] REG_COL_OFFSET   = 3'd3;
  localparam logic [2:0] REG_ROW_OFFSET   = 3'd4;

  typedef logic [NSUMS-1:0][SUM_W-1:0] sums_t;

  typedef struct packed {
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [10:0] window_size;
    logic [11:0] col_offset;
    logic [11:0] row_offset;
  } cfg_t;

  typedef struct packed {
    logic       err_emit;
    logic       in_win;
    logic       blk_first;
    logic       blk_done;
    logic [1:0] r;
    logic [1:0] c;
    logic [7:0] br;
    logic [7:0] bcol;
    logic       last;
  } loc_t;

endpackage

// ===== hw/rtl/bwps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bwps_cfg_regs
// Register bank behind the configuration port.
// ----------------------------------------------------------------------------
module bwps_cfg_regs import bwps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_IMAGE_WIDTH:  cfg_d.image_width  = pwdata[12:0];
        REG_IMAGE_HEIGHT: cfg_d.image_height = pwdata[12:0];
        REG_WINDOW_SIZE:  cfg_d.window_size  = pwdata[10:0];
        REG_COL_OFFSET:   cfg_d.col_offset   = pwdata[11:0];
        REG_ROW_OFFSET:   cfg_d.row_offset   = pwdata[11:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_IMAGE_WIDTH:  prdata = {19'd0, cfg_q.image_width};
      REG_IMAGE_HEIGHT: prdata = {19'd0, cfg_q.image_height};
      REG_WINDOW_SIZE:  prdata = {21'd0, cfg_q.window_size};
      REG_COL_OFFSET:   prdata = {20'd0, cfg_q.col_offset};
      REG_ROW_OFFSET:   prdata = {20'd0, cfg_q.row_offset};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= 13'd1024;
      cfg_q.image_height <= 13'd1024;
      cfg_q.window_size  <= 11'd1024;
      cfg_q.col_offset   <= 12'd0;
      cfg_q.row_offset   <= 12'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hw/rtl/bwps_locate.sv =====
// ----------------------------------------------------------------------------
// bwps_locate
// Pixel position counters and window and block decode for the incoming item.
// ----------------------------------------------------------------------------
module bwps_locate import bwps_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int AW         = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          accept_i,
  input  logic          frame_start_i,
  output loc_t          loc_o,
  output logic [AW-1:0] addr_o
);

  logic [11:0] row_q, row_d, col_q, col_d;
  logic [11:0] row, col, wr, wc;
  logic [12:0] w13, row_end, col_end, col_inc;
  logic        cfg_bad, row_in, col_in, wrap;

  assign row = frame_start_i ? 12'd0 : row_q;
  assign col = frame_start_i ? 12'd0 : col_q;

  assign w13     = {2'b00, cfg_i.window_size};
  assign row_end = {1'b0, cfg_i.row_offset} + w13;
  assign col_end = {1'b0, cfg_i.col_offset} + w13;

  assign cfg_bad = (cfg_i.window_size == 11'd0) ||
                   ((cfg_i.window_size & (cfg_i.window_size - 11'd1)) != 11'd0) ||
                   (w13 > 13'(MAX_WINDOW)) ||
                   (col_end > cfg_i.image_width) ||
                   (row_end > cfg_i.image_height);

  assign row_in = (row >= cfg_i.row_offset) && ({1'b0, row} < row_end);
  assign col_in = (col >= cfg_i.col_offset) && ({1'b0, col} < col_end);

  assign wr = row - cfg_i.row_offset;
  assign wc = col - cfg_i.col_offset;

  always_comb begin
    loc_o.err_emit  = cfg_bad && frame_start_i;
    loc_o.in_win    = !cfg_bad && row_in && col_in;
    loc_o.r         = wr[1:0];
    loc_o.c         = wc[1:0];
    loc_o.blk_first = (wr[1:0] == 2'd0) && (wc[1:0] == 2'd0);
    loc_o.blk_done  = (wr[1:0] == 2'd3) && (wc[1:0] == 2'd3);
    loc_o.br        = wr[9:2];
    loc_o.bcol      = wc[9:2];
    loc_o.last      = (({1'b0, wc[11:2]} + 11'd1) == {2'b00, cfg_i.window_size[10:2]}) &&
                      (({1'b0, wr[11:2]} + 11'd1) == {2'b00, cfg_i.window_size[10:2]});
  end

  assign addr_o = wc[2 +: AW];

  assign col_inc = {1'b0, col} + 13'd1;
  assign wrap    = (col_inc >= cfg_i.image_width) || (col == 12'hFFF);

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (accept_i) begin
      if (wrap) begin
        col_d = 12'd0;
        row_d = row + 12'd1;
      end else begin
        col_d = col_inc[11:0];
        row_d = row;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= 12'd0;
      col_q <= 12'd0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule

// ===== hw/rtl/bwps_line_store.sv =====
// ----------------------------------------------------------------------------
// bwps_line_store
// One entry of six partial sums per block column, with registered read and
// write-to-read bypass for back-to-back pixels of the same block column.
// ----------------------------------------------------------------------------
module bwps_line_store import bwps_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  sums_t         wr_data_i,
  output sums_t         rd_data_o
);

  sums_t mem [DEPTH];
  sums_t rd_q;

  assign rd_data_o = rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else begin
        rd_q <= mem[rd_addr_i];
      end
    end
  end

endmodule

// ===== hw/rtl/bwps_pattern.sv =====
// ----------------------------------------------------------------------------
// bwps_pattern
// Adds or subtracts one pixel into each of the six Walsh pattern sums.
// ----------------------------------------------------------------------------
module bwps_pattern import bwps_pkg::*; (
  input  sums_t            base_i,
  input  logic             first_i,
  input  logic [1:0]       r_i,
  input  logic [1:0]       c_i,
  input  logic [PIX_W-1:0] pix_i,
  output sums_t            sums_o
);

  logic [NSUMS-1:0] pos;
  logic [SUM_W-1:0] pix_ext;

  assign pix_ext = SUM_W'(pix_i);

  assign pos[0] = 1'b1;
  assign pos[1] = !r_i[1];
  assign pos[2] = !c_i[1];
  assign pos[3] = r_i[1] ~^ r_i[0];
  assign pos[4] = r_i[1] ~^ c_i[1];
  assign pos[5] = c_i[1] ~^ c_i[0];

  always_comb begin
    for (int k = 0; k < NSUMS; k++) begin
      if (pos[k]) begin
        sums_o[k] = (first_i ? '0 : base_i[k]) + pix_ext;
      end else begin
        sums_o[k] = (first_i ? '0 : base_i[k]) - pix_ext;
      end
    end
  end

endmodule

// ===== hw/rtl/block_walsh_pattern_sums_unit.sv =====
// ----------------------------------------------------------------------------
// block_walsh_pattern_sums_unit
// A result is loaded into the output register from the stage registers of
// the pixel that completes its 4x4 block, once the output register is free.
// Throughput: one pixel per cycle while the output side does not stall, set
// by the line store read-modify-write with a write-to-read bypass. Reset
// clears the position counters, the pipeline valids and the registers to
// their defaults; the line store is not cleared, since every block
// overwrites its entry on its first pixel.
// ----------------------------------------------------------------------------
module block_walsh_pattern_sums_unit import bwps_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // Fields from bit 0: pixel[15:0].
  input  logic [15:0]       s_axis_tdata_i,
  // Fields from bit 0: frame_start.
  input  logic [0:0]        s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // Fields from bit 0: block_row[7:0], block_col[7:0], sum_total[19:0],
  // top_minus_bottom, left_minus_right, outer_minus_inner_rows,
  // quadrant_checker, outer_minus_inner_cols (20 bits each).
  output logic [135:0]      m_axis_tdata_o,
  output logic              m_axis_tlast_o,
  // Fields from bit 0: config_error.
  output logic [0:0]        m_axis_tuser_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int DEPTH   = MAX_WINDOW / 4;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PIX_USE = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
  localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((32'd1 << PIX_USE) - 32'd1);

  cfg_t             cfg;
  loc_t             loc, loc_q;
  logic [AW-1:0]    addr, addr_q;
  logic [PIX_W-1:0] pix_q;
  logic             s1_valid_q, s1_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             accept, advance, s1_emit, out_free, wr_en;
  sums_t            rd_data, new_sums;
  sums_t            out_sums_q;
  logic [7:0]       out_br_q, out_bcol_q;
  logic             out_last_q, out_err_q;

  bwps_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bwps_locate #(
    .MAX_WINDOW (MAX_WINDOW),
    .AW         (AW)
  ) u_locate (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .accept_i      (accept),
    .frame_start_i (s_axis_tuser_i[0]),
    .loc_o         (loc),
    .addr_o        (addr)
  );

  bwps_line_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (addr),
    .wr_en_i   (wr_en),
    .wr_addr_i (addr_q),
    .wr_data_i (new_sums),
    .rd_data_o (rd_data)
  );

  bwps_pattern u_pattern (
    .base_i  (rd_data),
    .first_i (loc_q.blk_first),
    .r_i     (loc_q.r),
    .c_i     (loc_q.c),
    .pix_i   (pix_q),
    .sums_o  (new_sums)
  );

  assign s1_emit  = loc_q.err_emit || (loc_q.in_win && loc_q.blk_done);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign advance  = s1_valid_q && (!s1_emit || out_free);
  assign s_axis_tready_o = !s1_valid_q || advance;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_en    = advance && loc_q.in_win;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && s1_emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      loc_q  <= loc;
      addr_q <= addr;
      pix_q  <= s_axis_tdata_i & PIX_MASK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_emit) begin
      if (loc_q.err_emit) begin
        out_br_q   <= 8'd0;
        out_bcol_q <= 8'd0;
        out_sums_q <= '0;
        out_last_q <= 1'b0;
        out_err_q  <= 1'b1;
      end else begin
        out_br_q   <= loc_q.br;
        out_bcol_q <= loc_q.bcol;
        out_sums_q <= new_sums;
        out_last_q <= loc_q.last;
        out_err_q  <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_sums_q, out_bcol_q, out_br_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_err_q;

endmodule
